[hw/rtl/two_link_planar_forward_kinematics_defines.svh]
// Assertion macros shared by the checker files of the planar arm block.
// Depends on nothing; include it by its bare file name.
`ifndef TWO_LINK_PLANAR_FORWARD_KINEMATICS_DEFINES_SVH
`define TWO_LINK_PLANAR_FORWARD_KINEMATICS_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLFK_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("two_link_planar_forward_kinematics: check failed");

// The consequent must hold in the cycle after the antecedent.
`define TLFK_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("two_link_planar_forward_kinematics: check failed");

`endif

[hw/rtl/tlfk_pkg.sv]
// Shared types, constants and the sine table generator of the planar arm block.
// Depends on nothing; all but tlfk_ram and the defines header refer to it by scoped names.
`default_nettype none

package tlfk_pkg;

  localparam int CNT_W      = 12;
  localparam int OUT_W      = 12;
  localparam int LEN_W      = 10;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [LEN_W-1:0] UPPER_LEN_RESET = 10'd220;
  localparam logic [LEN_W-1:0] LOWER_LEN_RESET = 10'd147;

  localparam logic [63:0] HALF_PI_Q31 = 64'd3373259426;
  localparam logic [63:0] ONE_Q31     = 64'd2147483648;

  typedef enum logic {
    REG_UPPER_LINK,
    REG_LOWER_LINK
  } reg_idx_t;

  typedef enum logic {
    TBL_FILL,
    TBL_READY
  } tbl_state_t;

  typedef struct packed {
    logic wr_en;
    logic busy;
  } fill_status_t;

  // Unsigned quotient by restoring long division, one bit per step.
  function automatic logic [63:0] udiv64(input logic [63:0] num,
                                         input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // One quarter-wave entry, sin(k/Q * pi/2) scaled by 2^frac_bits and rounded.
  // Evaluated at elaboration only, with a Q31 integer Taylor series.
  function automatic logic [31:0] sine_entry(input int unsigned k,
                                             input int unsigned qtr_bits,
                                             input int unsigned frac_bits);
    logic [63:0] qsize;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] d;
    logic [63:0] nn;
    logic        want_sin;
    qsize = 64'd1 << qtr_bits;
    if (64'(k) <= (qsize >> 1)) begin
      x        = (64'(k) * HALF_PI_Q31) >> qtr_bits;
      want_sin = 1'b1;
    end else begin
      x        = ((qsize - 64'(k)) * HALF_PI_Q31) >> qtr_bits;
      want_sin = 1'b0;
    end
    x2   = (x * x) >> 31;
    term = want_sin ? x : ONE_Q31;
    sum  = term;
    for (int n = 1; n <= 8; n++) begin
      nn   = 64'(n);
      d    = want_sin ? (2 * nn) * (2 * nn + 1) : (2 * nn - 1) * (2 * nn);
      term = (term * x2) >> 31;
      term = udiv64(term, d);
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    if (sum > ONE_Q31) begin
      sum = ONE_Q31;
    end
    return 32'((sum + (64'd1 << (30 - frac_bits))) >> (31 - frac_bits));
  endfunction

endpackage

`default_nettype wire

[hw/rtl/tlfk_ram.sv]
// Generic synchronous RAM: one write port, two read ports with registered data.
// Depends on nothing.
`default_nettype none

module tlfk_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 1025
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

`default_nettype wire

[hw/rtl/tlfk_fill.sv]
// Sequencer that loads the quarter-wave sine table into the RAMs after reset.
// Depends on tlfk_pkg.
`default_nettype none

module tlfk_fill #(
  parameter int ANGLE_BITS     = 12,
  parameter int SINE_FRAC_BITS = 14
) (
  input  logic                         clk,
  input  logic                         rst,
  output tlfk_pkg::fill_status_t       status,
  output logic [ANGLE_BITS-2:0]        wr_addr,
  output logic [SINE_FRAC_BITS:0]      wr_data
);

  localparam int QTR_BITS = ANGLE_BITS - 2;
  localparam int QTR_SIZE = 1 << QTR_BITS;
  localparam int ADDR_W   = QTR_BITS + 1;
  localparam int MAG_W    = SINE_FRAC_BITS + 1;
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(QTR_SIZE);

  tlfk_pkg::tbl_state_t state;
  tlfk_pkg::tbl_state_t state_next;
  logic [ADDR_W-1:0]    fill_idx;
  logic [ADDR_W-1:0]    fill_idx_next;
  logic [MAG_W-1:0]     rom [QTR_SIZE+1];

  // Entries are worked out at elaboration; this is the source of the sweep.
  for (genvar k = 0; k <= QTR_SIZE; k++) begin : g_rom
    localparam logic [31:0] ENTRY = tlfk_pkg::sine_entry(k, QTR_BITS, SINE_FRAC_BITS);
    assign rom[k] = ENTRY[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tlfk_pkg::TBL_FILL;
      fill_idx <= '0;
    end else begin
      state    <= state_next;
      fill_idx <= fill_idx_next;
    end
  end

  always_comb begin
    state_next    = state;
    fill_idx_next = fill_idx;
    status.wr_en  = 1'b0;
    status.busy   = 1'b1;
    case (state)
      tlfk_pkg::TBL_FILL: begin
        status.wr_en = 1'b1;
        if (fill_idx == LAST_IDX) begin
          state_next = tlfk_pkg::TBL_READY;
        end else begin
          fill_idx_next = fill_idx + 1'b1;
        end
      end
      tlfk_pkg::TBL_READY: begin
        status.busy = 1'b0;
      end
      default: begin
        state_next = tlfk_pkg::TBL_FILL;
      end
    endcase
  end

  assign wr_addr = fill_idx;
  assign wr_data = rom[fill_idx];

endmodule

`default_nettype wire

[hw/rtl/tlfk_regs.sv]
// APB-style register file holding the two link lengths.
// Depends on tlfk_pkg.
`default_nettype none

module tlfk_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tlfk_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [tlfk_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [tlfk_pkg::APB_DATA_W-1:0]     prdata,
  output logic [tlfk_pkg::LEN_W-1:0]          upper_len,
  output logic [tlfk_pkg::LEN_W-1:0]          lower_len
);

  logic               wr_beat;
  tlfk_pkg::reg_idx_t reg_sel;

  assign wr_beat = psel && penable && pwrite;
  assign reg_sel = tlfk_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_len <= tlfk_pkg::UPPER_LEN_RESET;
      lower_len <= tlfk_pkg::LOWER_LEN_RESET;
    end else if (wr_beat) begin
      case (reg_sel)
        tlfk_pkg::REG_UPPER_LINK: upper_len <= pwdata[tlfk_pkg::LEN_W-1:0];
        tlfk_pkg::REG_LOWER_LINK: lower_len <= pwdata[tlfk_pkg::LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      tlfk_pkg::REG_UPPER_LINK: prdata = tlfk_pkg::APB_DATA_W'(upper_len);
      tlfk_pkg::REG_LOWER_LINK: prdata = tlfk_pkg::APB_DATA_W'(lower_len);
      default:                  prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/tlfk_calc.sv]
// Four-stage kinematics datapath: table reads, products, sums, truncation.
// Depends on tlfk_pkg and tlfk_ram.
`default_nettype none

module tlfk_calc #(
  parameter int ANGLE_BITS     = 12,
  parameter int SINE_FRAC_BITS = 14
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 accept,
  input  logic [tlfk_pkg::CNT_W-1:0]           shoulder_count,
  input  logic [tlfk_pkg::CNT_W-1:0]           elbow_count,
  input  logic [tlfk_pkg::LEN_W-1:0]           upper_len,
  input  logic [tlfk_pkg::LEN_W-1:0]           lower_len,
  input  tlfk_pkg::fill_status_t               fill,
  input  logic [ANGLE_BITS-2:0]                wr_addr,
  input  logic [SINE_FRAC_BITS:0]              wr_data,
  output logic                                 done,
  output logic signed [tlfk_pkg::OUT_W-1:0]    tip_x,
  output logic signed [tlfk_pkg::OUT_W-1:0]    tip_y
);

  localparam int QTR_BITS = ANGLE_BITS - 2;
  localparam int QTR_SIZE = 1 << QTR_BITS;
  localparam int ADDR_W   = QTR_BITS + 1;
  localparam int MAG_W    = SINE_FRAC_BITS + 1;
  localparam int PROD_W   = MAG_W + tlfk_pkg::LEN_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int WIDE_W   = ANGLE_BITS + tlfk_pkg::CNT_W;
  localparam logic [ANGLE_BITS-1:0] ANGLE_OFFSET = ANGLE_BITS'(3 * QTR_SIZE);
  localparam logic [SUM_W-1:0]      TRUNC_BIAS   = SUM_W'((1 << SINE_FRAC_BITS) - 1);

  // Mirrored address into the quarter-wave table for quadrants one and three.
  function automatic logic [ADDR_W-1:0] tab_addr(input logic [1:0] quad,
                                                  input logic [QTR_BITS-1:0] idx);
    logic [ADDR_W-1:0] fwd;
    fwd = {1'b0, idx};
    return quad[0] ? (ADDR_W'(QTR_SIZE) - fwd) : fwd;
  endfunction

  function automatic logic signed [SUM_W-1:0] apply_sign(input logic [PROD_W-1:0] mag,
                                                        input logic neg);
    logic signed [SUM_W-1:0] ext;
    ext = $signed({1'b0, mag});
    return neg ? -ext : ext;
  endfunction

  // Truncation toward zero to whole millimetres.
  function automatic logic [tlfk_pkg::OUT_W-1:0] to_mm(input logic signed [SUM_W-1:0] s);
    logic [SUM_W-1:0] biased;
    biased = s[SUM_W-1] ? (SUM_W'(s) + TRUNC_BIAS) : SUM_W'(s);
    return biased[SUM_W-1 -: tlfk_pkg::OUT_W];
  endfunction

  logic [WIDE_W-1:0]     sh_wide;
  logic [WIDE_W-1:0]     el_wide;
  logic [ANGLE_BITS-1:0] sh;
  logic [ANGLE_BITS-1:0] el;
  logic [ANGLE_BITS-1:0] ang_a;
  logic [ANGLE_BITS-1:0] ang_b;
  logic [1:0]            quad_sa;
  logic [1:0]            quad_ca;
  logic [1:0]            quad_sb;
  logic [1:0]            quad_cb;
  logic [MAG_W-1:0]      mag_sa;
  logic [MAG_W-1:0]      mag_ca;
  logic [MAG_W-1:0]      mag_sb;
  logic [MAG_W-1:0]      mag_cb;

  logic                  v1;
  logic [3:0]            neg1;
  logic                  v2;
  logic [3:0]            neg2;
  logic [PROD_W-1:0]     prod_sa;
  logic [PROD_W-1:0]     prod_ca;
  logic [PROD_W-1:0]     prod_sb;
  logic [PROD_W-1:0]     prod_cb;
  logic                  v3;
  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;

  assign sh_wide = WIDE_W'(shoulder_count);
  assign el_wide = WIDE_W'(elbow_count);
  assign sh      = sh_wide[ANGLE_BITS-1:0];
  assign el      = el_wide[ANGLE_BITS-1:0];
  assign ang_a   = sh - ANGLE_OFFSET;
  assign ang_b   = sh + el - ANGLE_OFFSET;

  // Cosine is the sine one quadrant further on.
  assign quad_sa = ang_a[ANGLE_BITS-1 -: 2];
  assign quad_ca = quad_sa + 2'd1;
  assign quad_sb = ang_b[ANGLE_BITS-1 -: 2];
  assign quad_cb = quad_sb + 2'd1;

  tlfk_ram #(
    .WIDTH (MAG_W),
    .DEPTH (QTR_SIZE + 1)
  ) u_ram_a (
    .clk       (clk),
    .wr_en     (fill.wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (tab_addr(quad_sa, ang_a[QTR_BITS-1:0])),
    .rd_addr_b (tab_addr(quad_ca, ang_a[QTR_BITS-1:0])),
    .rd_data_a (mag_sa),
    .rd_data_b (mag_ca)
  );

  tlfk_ram #(
    .WIDTH (MAG_W),
    .DEPTH (QTR_SIZE + 1)
  ) u_ram_b (
    .clk       (clk),
    .wr_en     (fill.wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (tab_addr(quad_sb, ang_b[QTR_BITS-1:0])),
    .rd_addr_b (tab_addr(quad_cb, ang_b[QTR_BITS-1:0])),
    .rd_data_a (mag_sb),
    .rd_data_b (mag_cb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= accept;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

  always_ff @(posedge clk) begin
    neg1    <= {quad_sa[1], quad_ca[1], quad_sb[1], quad_cb[1]};
    neg2    <= neg1;
    prod_sa <= PROD_W'(mag_sa) * PROD_W'(upper_len);
    prod_ca <= PROD_W'(mag_ca) * PROD_W'(upper_len);
    prod_sb <= PROD_W'(mag_sb) * PROD_W'(lower_len);
    prod_cb <= PROD_W'(mag_cb) * PROD_W'(lower_len);
    sum_x   <= apply_sign(prod_ca, neg2[2]) + apply_sign(prod_cb, neg2[0]);
    sum_y   <= apply_sign(prod_sa, neg2[3]) + apply_sign(prod_sb, neg2[1]);
    tip_x   <= $signed(to_mm(sum_x));
    tip_y   <= $signed(to_mm(sum_y));
  end

endmodule

`default_nettype wire

[hw/rtl/two_link_planar_forward_kinematics.sv]
// Results: done/tip_x/tip_y are registered behind the table read, product, sum and truncation stages.
// Throughput: one item per cycle when not busy, set by the two dual-read sine RAMs (four lookups a cycle).
// Reset: link lengths return to 220 mm and 147 mm; busy stays high while the sine table is loaded.
// Results cannot be held off by the receiver; done marks each for exactly one cycle.
`default_nettype none

module two_link_planar_forward_kinematics #(
  parameter int ANGLE_BITS     = 12,
  parameter int SINE_FRAC_BITS = 14
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [tlfk_pkg::CNT_W-1:0]           shoulder_count,
  input  logic [tlfk_pkg::CNT_W-1:0]           elbow_count,
  output logic                                 done,
  output logic signed [tlfk_pkg::OUT_W-1:0]    tip_x,
  output logic signed [tlfk_pkg::OUT_W-1:0]    tip_y,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [tlfk_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [tlfk_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [tlfk_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready
);

  // The block is a fixed pipeline around two copies of one quarter-wave sine
  // table. Each copy serves one link: one read port gives the sine of the link
  // angle and the other gives its cosine, so all four lookups of an item are
  // served together and, while not busy, a new item can enter on every cycle.
  //
  // Stage 0 forms the link angles and the mirrored table addresses from the
  // input beat; the RAMs register their read data at the accepting edge.
  // Stage 1 multiplies each magnitude by its link length. Stage 2 applies the
  // quadrant signs and adds the two links per axis. Stage 3 truncates toward
  // zero and drives the result beat.
  //
  // The tables are loaded by a sweep after every reset. No item is taken while
  // the sweep runs, which is the only interlock between table writes and the
  // reads of the datapath; after it the tables are read only.

  tlfk_pkg::fill_status_t        fill;
  logic [ANGLE_BITS-2:0]         fill_addr;
  logic [SINE_FRAC_BITS:0]       fill_data;
  logic [tlfk_pkg::LEN_W-1:0]    upper_len;
  logic [tlfk_pkg::LEN_W-1:0]    lower_len;
  logic                          accept;

  // Reset also blocks the start beat, so nothing is accepted before the sweep.
  assign busy   = rst | fill.busy;
  assign accept = start & ~busy;
  assign pready = 1'b1;

  tlfk_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .upper_len (upper_len),
    .lower_len (lower_len)
  );

  tlfk_fill #(
    .ANGLE_BITS     (ANGLE_BITS),
    .SINE_FRAC_BITS (SINE_FRAC_BITS)
  ) u_fill (
    .clk     (clk),
    .rst     (rst),
    .status  (fill),
    .wr_addr (fill_addr),
    .wr_data (fill_data)
  );

  tlfk_calc #(
    .ANGLE_BITS     (ANGLE_BITS),
    .SINE_FRAC_BITS (SINE_FRAC_BITS)
  ) u_calc (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .shoulder_count (shoulder_count),
    .elbow_count    (elbow_count),
    .upper_len      (upper_len),
    .lower_len      (lower_len),
    .fill           (fill),
    .wr_addr        (fill_addr),
    .wr_data        (fill_data),
    .done           (done),
    .tip_x          (tip_x),
    .tip_y          (tip_y)
  );

endmodule

`default_nettype wire

[hw/rtl/tlfk_checker.sv]
// Port-level checks of the planar arm block and the bind that attaches them.
// Depends on tlfk_pkg, two_link_planar_forward_kinematics_defines.svh and the top level.
`default_nettype none

`include "two_link_planar_forward_kinematics_defines.svh"

module tlfk_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              done,
  input logic signed [tlfk_pkg::OUT_W-1:0] tip_x,
  input logic signed [tlfk_pkg::OUT_W-1:0] tip_y
);

  localparam logic signed [tlfk_pkg::OUT_W-1:0] MAX_REACH = 12'sd2046;

  // Every accepted beat yields its result beat.
  `TLFK_ASSERT_IMPLY(a_result_follows, clk, rst, start && !busy, ##4 done)

  // No result beat appears without an accepted beat before it.
  `TLFK_ASSERT_IMPLY(a_no_spurious_result, clk, rst, done, $past(start && !busy, 4))

  // Once the table load ends, busy stays low until the next reset.
  `TLFK_ASSERT_NEXT(a_ready_sticks, clk, rst, !busy, !busy)

  // A reach beyond two full-length links cannot occur.
  `TLFK_ASSERT_IMPLY(a_reach_x, clk, rst, done, (tip_x <= MAX_REACH) && (tip_x >= -MAX_REACH))
  `TLFK_ASSERT_IMPLY(a_reach_y, clk, rst, done, (tip_y <= MAX_REACH) && (tip_y >= -MAX_REACH))

endmodule

bind two_link_planar_forward_kinematics tlfk_checker u_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .tip_x (tip_x),
  .tip_y (tip_y)
);

`default_nettype wire
